// ----- rtl/text_console_engine_macros.svh -----
// assertion macros shared by the console rtl
// clock i_clk and active-low reset i_rst_n are taken from the using module
`ifndef TEXT_CONSOLE_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_ENGINE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define TCE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console assertion failed");

// next-cycle implication
`define TCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("console assertion failed");

`else

`define TCE_ASSERT_IMPL(label, ante, cons)
`define TCE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/tce_pkg.sv -----
package tce_pkg;

    // field widths
    localparam int FUNC_W = 1;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // default geometry
    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // item functions
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

    // byte codes
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_H        = 8'h48;
    localparam logic [CHAR_W-1:0] CH_TWO      = 8'h32;
    localparam logic [CHAR_W-1:0] CH_J        = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;

    // escape parser phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2,
        PH_CSI2 = 2'd3
    } t_esc_phase;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_FINISH
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic capture;
        logic sweep_run;
        logic sweep_copy;
        logic sweep_rst_attr;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic need_clear;
        logic sweep_done;
    } t_dp_status;

endpackage

// ----- rtl/tce_ifs.sv -----
// request channel: one byte write or one cell read
interface tce_req_if;
    logic                        valid;
    logic                        ready;
    logic [tce_pkg::FUNC_W-1:0]  func;
    logic [tce_pkg::CHAR_W-1:0]  character;
    logic [tce_pkg::IDX_W-1:0]   cell_index;

    modport source (output valid, func, character, cell_index, input ready);
    modport sink   (input valid, func, character, cell_index, output ready);
endinterface

// response channel: one result per request
interface tce_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tce_pkg::CELL_W-1:0]  read_data;
    logic [tce_pkg::POS_W-1:0]   cursor_position;
    logic                        cursor_written;

    modport source (output valid, read_data, cursor_position, cursor_written, input ready);
    modport sink   (input valid, read_data, cursor_position, cursor_written, output ready);
endinterface

// ----- rtl/tce_ram.sv -----
module tce_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tce_ctrl.sv -----
`include "text_console_engine_macros.svh"

module tce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tce_pkg::t_dp_cmd    o_cmd,
    input  tce_pkg::t_dp_status i_sts
);

    tce_pkg::t_ctrl_state r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic                 in_fire;
    logic                 out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tce_pkg::ST_INIT: begin
                if (i_sts.sweep_done) n_state = tce_pkg::ST_IDLE;
            end
            tce_pkg::ST_IDLE: begin
                if (in_fire) n_state = tce_pkg::ST_EXEC;
            end
            tce_pkg::ST_EXEC: begin
                if (i_sts.is_read)          n_state = tce_pkg::ST_READ;
                else if (i_sts.need_clear)  n_state = tce_pkg::ST_CLEAR;
                else if (i_sts.need_scroll) n_state = tce_pkg::ST_SCROLL;
                else                        n_state = tce_pkg::ST_FINISH;
            end
            tce_pkg::ST_READ: begin
                n_state = tce_pkg::ST_FINISH;
            end
            tce_pkg::ST_SCROLL, tce_pkg::ST_CLEAR: begin
                if (i_sts.sweep_done) n_state = tce_pkg::ST_FINISH;
            end
            tce_pkg::ST_FINISH: begin
                if (out_free) n_state = tce_pkg::ST_IDLE;
            end
            default: n_state = tce_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            tce_pkg::ST_INIT: begin
                o_cmd.sweep_run      = 1'b1;
                o_cmd.sweep_rst_attr = 1'b1;
            end
            tce_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            tce_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            tce_pkg::ST_READ: begin
                o_cmd.capture = 1'b1;
            end
            tce_pkg::ST_SCROLL: begin
                o_cmd.sweep_run  = 1'b1;
                o_cmd.sweep_copy = 1'b1;
            end
            tce_pkg::ST_CLEAR: begin
                o_cmd.sweep_run = 1'b1;
            end
            tce_pkg::ST_FINISH: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tce_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TCE_ASSERT_NEXT(a_fire_to_exec, in_fire, r_state == tce_pkg::ST_EXEC)
    `TCE_ASSERT_NEXT(a_read_path, (r_state == tce_pkg::ST_EXEC) && i_sts.is_read, r_state == tce_pkg::ST_READ)
    `TCE_ASSERT_NEXT(a_scroll_hold, (r_state == tce_pkg::ST_SCROLL) && !i_sts.sweep_done, r_state == tce_pkg::ST_SCROLL)

endmodule

// ----- rtl/tce_datapath.sv -----
`include "text_console_engine_macros.svh"

module tce_datapath #(
    parameter int unsigned COLUMNS = tce_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS    = tce_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tce_pkg::t_dp_cmd            i_cmd,
    output tce_pkg::t_dp_status         o_sts,
    input  logic [tce_pkg::FUNC_W-1:0]  i_func,
    input  logic [tce_pkg::CHAR_W-1:0]  i_character,
    input  logic [tce_pkg::IDX_W-1:0]   i_cell_index,
    input  logic                        i_cfg_wr_en,
    input  logic [tce_pkg::ATTR_W-1:0]  i_cfg_wr_data,
    output logic [tce_pkg::CELL_W-1:0]  o_read_data,
    output logic [tce_pkg::POS_W-1:0]   o_cursor_position,
    output logic                        o_cursor_written
);

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned KW    = $clog2(CELLS + 1);
    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned RW    = $clog2(ROWS);

    // latched item
    logic [tce_pkg::FUNC_W-1:0] r_func;
    logic [tce_pkg::CHAR_W-1:0] r_char;
    logic [tce_pkg::IDX_W-1:0]  r_idx;

    // console state
    logic [tce_pkg::ATTR_W-1:0] r_attr;
    tce_pkg::t_esc_phase        r_phase, n_phase;
    logic [RW-1:0]              r_row, n_row;
    logic [CW-1:0]              r_col, n_col;
    logic [KW-1:0]              r_sweep;

    // result registers
    logic [tce_pkg::CELL_W-1:0] r_data;
    logic                       r_wrote;
    logic [tce_pkg::CELL_W-1:0] r_out_data;
    logic [tce_pkg::POS_W-1:0]  r_out_pos;
    logic                       r_out_wrote;

    // execute results
    logic ex_wrote, ex_print, ex_scroll, ex_clear, adv_row;

    // memory ports
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [tce_pkg::CELL_W-1:0] ram_wdata, ram_rdata, blank_cell;
    logic [AW-1:0]              cur_addr;
    logic                       idx_in_range;
    logic                       sweep_done;
    logic                       sweep_src_ok;
    logic                       sweep_copy_ok;

    assign cur_addr     = AW'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));
    assign idx_in_range = 32'(r_idx) < 32'(CELLS);
    assign sweep_done   = i_cmd.sweep_run && (r_sweep == KW'(CELLS));
    assign sweep_src_ok = 32'(r_sweep) < 32'(CELLS - COLUMNS);
    assign sweep_copy_ok = 32'(r_sweep) <= 32'(CELLS - COLUMNS);
    assign blank_cell   = {(i_cmd.sweep_rst_attr ? tce_pkg::RESET_ATTR : r_attr),
                           tce_pkg::CH_SPACE};

    // byte interpreter
    always_comb begin
        n_phase   = r_phase;
        n_row     = r_row;
        n_col     = r_col;
        ex_wrote  = 1'b0;
        ex_print  = 1'b0;
        ex_scroll = 1'b0;
        ex_clear  = 1'b0;
        adv_row   = 1'b0;
        if (r_func == tce_pkg::FUNC_WRITE) begin
            unique case (r_phase)
                tce_pkg::PH_ESC: begin
                    n_phase = (r_char == tce_pkg::CH_LBRACKET) ? tce_pkg::PH_CSI
                                                               : tce_pkg::PH_IDLE;
                end
                tce_pkg::PH_CSI: begin
                    if (r_char == tce_pkg::CH_TWO) begin
                        n_phase = tce_pkg::PH_CSI2;
                    end else begin
                        n_phase = tce_pkg::PH_IDLE;
                        if (r_char == tce_pkg::CH_H) begin
                            n_row    = '0;
                            n_col    = '0;
                            ex_wrote = 1'b1;
                        end
                    end
                end
                tce_pkg::PH_CSI2: begin
                    n_phase = tce_pkg::PH_IDLE;
                    if (r_char == tce_pkg::CH_J) begin
                        n_row    = '0;
                        n_col    = '0;
                        ex_clear = 1'b1;
                        ex_wrote = 1'b1;
                    end
                end
                tce_pkg::PH_IDLE: begin
                    ex_wrote = 1'b1;
                    if (r_char == tce_pkg::CH_ESC) begin
                        n_phase  = tce_pkg::PH_ESC;
                        ex_wrote = 1'b0;
                    end else if (r_char == tce_pkg::CH_CR) begin
                        n_col = '0;
                    end else if (r_char == tce_pkg::CH_BS) begin
                        // non-erasing, wraps back to the end of the previous row
                        if (r_col != '0) begin
                            n_col = r_col - CW'(1);
                        end else if (r_row != '0) begin
                            n_row = r_row - RW'(1);
                            n_col = CW'(COLUMNS - 1);
                        end
                    end else begin
                        if (r_char == tce_pkg::CH_LF) begin
                            n_col   = '0;
                            adv_row = 1'b1;
                        end else begin
                            ex_print = 1'b1;
                            if (r_col == CW'(COLUMNS - 1)) begin
                                n_col   = '0;
                                adv_row = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        // past the last row the screen scrolls and the cursor stays
                        if (adv_row) begin
                            if (r_row == RW'(ROWS - 1)) ex_scroll = 1'b1;
                            else                        n_row = r_row + RW'(1);
                        end
                    end
                end
                default: n_phase = tce_pkg::PH_IDLE;
            endcase
        end
    end

    // memory port selection: sweep copies row below, or blanks
    always_comb begin
        if (i_cmd.sweep_run) begin
            ram_we    = (r_sweep != '0);
            ram_waddr = AW'(r_sweep - KW'(1));
            ram_wdata = (i_cmd.sweep_copy && sweep_copy_ok) ? ram_rdata : blank_cell;
            ram_raddr = sweep_src_ok ? AW'(r_sweep + KW'(COLUMNS)) : '0;
        end else begin
            ram_we    = i_cmd.exec && ex_print;
            ram_waddr = cur_addr;
            ram_wdata = {r_attr, r_char};
            ram_raddr = idx_in_range ? AW'(r_idx) : '0;
        end
    end

    tce_ram #(
        .WIDTH (tce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= tce_pkg::RESET_ATTR;
            r_phase <= tce_pkg::PH_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cfg_wr_en) r_attr <= i_cfg_wr_data;
            if (i_cmd.exec) begin
                r_phase <= n_phase;
                r_row   <= n_row;
                r_col   <= n_col;
            end
            if (i_cmd.sweep_run) begin
                r_sweep <= sweep_done ? '0 : r_sweep + KW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_char <= i_character;
            r_idx  <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_data  <= '0;
            r_wrote <= ex_wrote;
        end
        if (i_cmd.capture) begin
            r_data <= idx_in_range ? ram_rdata : '0;
        end
        if (i_cmd.load_out) begin
            r_out_data  <= r_data;
            r_out_pos   <= tce_pkg::POS_W'(cur_addr);
            r_out_wrote <= r_wrote;
        end
    end

    assign o_sts.is_read     = (r_func == tce_pkg::FUNC_READ);
    assign o_sts.need_scroll = ex_scroll;
    assign o_sts.need_clear  = ex_clear;
    assign o_sts.sweep_done  = sweep_done;

    assign o_read_data       = r_out_data;
    assign o_cursor_position = r_out_pos;
    assign o_cursor_written  = r_out_wrote;

    `TCE_ASSERT_IMPL(a_cursor_range, 1'b1, (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)))
    `TCE_ASSERT_IMPL(a_sweep_bound, 1'b1, 32'(r_sweep) <= 32'(CELLS))

endmodule

// ----- rtl/text_console_engine.sv -----
// Character-cell text console: a write beat feeds one byte (printable text, CR, LF,
// non-erasing backspace, ESC [ H home, ESC [ 2 J clear) and a read beat returns one
// 16-bit cell (attribute high, character low); every request gives exactly one
// response beat with the cursor position. A scroll or a screen clear is a sweep
// through the single-write-port cell memory, one cell per cycle. The next request
// can be accepted in the cycle after a response is loaded, and not before. After
// reset a clearing pass over every cell runs before the first request is accepted;
// the attribute register may be written at any time the block is idle. A response
// left waiting does not block the next request from being accepted.
module text_console_engine #(
    parameter int unsigned COLUMNS = tce_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS    = tce_pkg::DEF_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tce_req_if.sink                    i_req,
    tce_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_wr_en,
    input  logic [tce_pkg::ATTR_W-1:0] i_cfg_wr_data
);

    tce_pkg::t_dp_cmd    w_cmd;
    tce_pkg::t_dp_status w_sts;
    logic                w_in_ready;
    logic                w_out_valid;

    // sequencing
    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // console state and cell memory
    tce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_func            (i_req.func),
        .i_character       (i_req.character),
        .i_cell_index      (i_req.cell_index),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_read_data       (o_rsp.read_data),
        .o_cursor_position (o_rsp.cursor_position),
        .o_cursor_written  (o_rsp.cursor_written)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

// ----- tb/sv/console_checker.sv -----
// watches the request and response channels of the console, keeps its own
// screen image and parser state, and compares every response beat in order
module console_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tce_req_if                         i_req,
    tce_rsp_if                         i_rsp,
    input  logic                       i_cfg_wr_en,
    input  logic [tce_pkg::ATTR_W-1:0] i_cfg_wr_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import tce_pkg::*;

    localparam int unsigned NCOL  = DEF_COLUMNS;
    localparam int unsigned NROW  = DEF_ROWS;
    localparam int unsigned NCELL = NCOL * NROW;
    localparam int          PRINT_CAP = 40;

    typedef struct packed {
        logic [CELL_W-1:0] read_data;
        logic [POS_W-1:0]  cursor_position;
        logic              cursor_written;
    } console_beat_t;

    // screen image and cursor as the block should hold them
    logic [CELL_W-1:0] screen [NCELL];
    int unsigned       cur_row;
    int unsigned       cur_col;
    t_esc_phase        esc_state;
    logic [ATTR_W-1:0] attr;

    console_beat_t expected_beats[$];
    int            fail_total = 0;

    task automatic report_diff(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (fail_total < PRINT_CAP) begin
            $display("%0t: %s got %h expected %h", $time, what, got, want);
        end
        fail_total++;
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < NCELL; i++) begin
            screen[i] = {attr, CH_SPACE};
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void scroll_up();
        for (int i = 0; i < NCELL - NCOL; i++) begin
            screen[i] = screen[i + NCOL];
        end
        for (int i = NCELL - NCOL; i < NCELL; i++) begin
            screen[i] = {attr, CH_SPACE};
        end
        cur_row = NROW - 1;
    endfunction

    // one byte through the escape parser and the cursor logic
    // returns 1 when the cursor register gets written
    function automatic logic feed_byte(input logic [CHAR_W-1:0] c);
        int unsigned at;
        case (esc_state)
            PH_ESC: begin
                esc_state = (c == CH_LBRACKET) ? PH_CSI : PH_IDLE;
                return 1'b0;
            end
            PH_CSI: begin
                if (c == CH_TWO) begin
                    esc_state = PH_CSI2;
                    return 1'b0;
                end
                esc_state = PH_IDLE;
                if (c == CH_H) begin
                    cur_row = 0;
                    cur_col = 0;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_CSI2: begin
                esc_state = PH_IDLE;
                if (c == CH_J) begin
                    blank_screen();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: ;
        endcase
        if (c == CH_ESC) begin
            esc_state = PH_ESC;
            return 1'b0;
        end
        if (c == CH_CR) begin
            cur_col = 0;
            return 1'b1;
        end
        // backspace never erases and stops at home
        if (c == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
            end else if (cur_row > 0) begin
                cur_row--;
                cur_col = NCOL - 1;
            end
            return 1'b1;
        end
        if (c == CH_LF) begin
            cur_col = 0;
            cur_row++;
        end else begin
            at = cur_row * NCOL + cur_col;
            if (at < NCELL) begin
                screen[at] = {attr, c};
            end
            cur_col++;
            if (cur_col >= NCOL) begin
                cur_col = 0;
                cur_row++;
            end
        end
        if (cur_row >= NROW) begin
            scroll_up();
        end
        return 1'b1;
    endfunction

    function automatic console_beat_t predict_beat(input logic [FUNC_W-1:0] f,
                                                   input logic [CHAR_W-1:0] c,
                                                   input logic [IDX_W-1:0]  x);
        console_beat_t r;
        r = '0;
        if (f == FUNC_WRITE) begin
            r.cursor_written = feed_byte(c);
        end else if (x < NCELL) begin
            r.read_data = screen[x];
        end
        r.cursor_position = POS_W'(cur_row * NCOL + cur_col);
        return r;
    endfunction

    // model update and compare on every clock edge
    always @(posedge i_clk) begin
        console_beat_t want;
        console_beat_t got;
        if (!i_rst_n) begin
            attr      = RESET_ATTR;
            esc_state = PH_IDLE;
            blank_screen();
            expected_beats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                attr = i_cfg_wr_data;
            end
            // response beat against the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                got.read_data       = i_rsp.read_data;
                got.cursor_position = i_rsp.cursor_position;
                got.cursor_written  = i_rsp.cursor_written;
                if (expected_beats.size() == 0) begin
                    report_diff("unexpected response beat", 32'(got), 32'(0));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.read_data !== want.read_data) begin
                        report_diff("read_data", 32'(got.read_data), 32'(want.read_data));
                    end
                    if (got.cursor_position !== want.cursor_position) begin
                        report_diff("cursor_position", 32'(got.cursor_position),
                                    32'(want.cursor_position));
                    end
                    if (got.cursor_written !== want.cursor_written) begin
                        report_diff("cursor_written", 32'(got.cursor_written),
                                    32'(want.cursor_written));
                    end
                end
            end
            // accepted request beat gives one prediction
            if (i_req.valid && i_req.ready) begin
                expected_beats.push_back(predict_beat(i_req.func, i_req.character,
                                                      i_req.cell_index));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_beats.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// stimulus and verdict for the console: directed bytes first, then random
// text, control and escape sequences under several idle and stall mixes
module testbench;
    import tce_pkg::*;

    localparam int NCELL         = DEF_COLUMNS * DEF_ROWS;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 180;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [ATTR_W-1:0] cfg_wr_data;
    int                idle_pct = 0;
    int                stall_pct = 0;
    logic              rsp_hold = 1'b0;
    logic [POS_W-1:0]  recent_pos = '0;
    int                items_sent = 0;
    int                cycle_count = 0;
    int                fail_count;
    int                pending;

    tce_req_if req_ch();
    tce_rsp_if rsp_ch();

    text_console_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    console_checker console_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // response side: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= stall_pct);
            if (rsp_ch.valid && rsp_ch.ready) begin
                recent_pos <= rsp_ch.cursor_position;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_engine: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                             input logic [IDX_W-1:0] x);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.character  <= c;
        req_ch.cell_index <= x;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // unused fields carry random values so the block must ignore them
    task automatic send_write(input logic [CHAR_W-1:0] c);
        send_beat(FUNC_WRITE, c, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic send_read(input logic [IDX_W-1:0] x);
        send_beat(FUNC_READ, CHAR_W'($urandom_range(0, 255)), x);
    endtask

    task automatic send_home();
        send_write(CH_ESC);
        send_write(CH_LBRACKET);
        send_write(CH_H);
    endtask

    task automatic send_clear();
        send_write(CH_ESC);
        send_write(CH_LBRACKET);
        send_write(CH_TWO);
        send_write(CH_J);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_attr(input logic [ATTR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // one random sequence: reads, text, controls, escapes, broken escapes
    task automatic play_sequence();
        int unsigned pick;
        int unsigned len;
        int unsigned depth;
        int unsigned back;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            // reads: anywhere, past the screen, or just behind the cursor
            back = $urandom_range(0, 120);
            case ($urandom_range(0, 9))
                0: send_read(IDX_W'($urandom_range(0, 2047)));
                1, 2, 3, 4: send_read(IDX_W'($urandom_range(0, NCELL - 1)));
                default: send_read((recent_pos > back) ? recent_pos - IDX_W'(back) : '0);
            endcase
        end else if (pick < 56) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
            repeat (len) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_write(CHAR_W'($urandom_range(0, 255)));
                end else begin
                    send_write(CHAR_W'($urandom_range(32, 126)));
                end
            end
        end else if (pick < 68) begin
            if ($urandom_range(0, 1) == 1) begin
                send_write(CH_CR);
            end
            send_write(CH_LF);
        end else if (pick < 73) begin
            send_write(CH_CR);
        end else if (pick < 78) begin
            repeat ($urandom_range(1, 3)) send_write(CH_BS);
        end else if (pick < 81) begin
            send_home();
        end else if (pick < 84) begin
            send_clear();
        end else if (pick < 87) begin
            // run of line feeds to reach the bottom and scroll
            repeat ($urandom_range(4, 30)) send_write(CH_LF);
        end else begin
            depth = $urandom_range(1, 3);
            send_write(CH_ESC);
            if (depth >= 2) begin
                send_write(CH_LBRACKET);
            end
            if (depth == 3) begin
                send_write(CH_TWO);
            end
            send_write(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int stop_at;
        i_rst_n           <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_WRITE;
        req_ch.character  <= '0;
        req_ch.cell_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents, the last cell and an index past the screen
        send_read('0);
        send_read(IDX_W'(NCELL - 1));
        send_read('1);
        // a printable byte and the highest and lowest byte values are stored
        send_write(8'h41);
        send_write(8'hFF);
        send_write(8'h00);
        // backspace, carriage return, backspace at home, line feed,
        // backspace from column 0 back onto the previous row
        send_write(CH_BS);
        send_write(CH_CR);
        send_write(CH_BS);
        send_write(CH_LF);
        send_write(CH_BS);
        // print in the last column wraps to the next row
        send_write(8'h7A);
        send_home();
        // unknown byte after ESC, after ESC [ and after ESC [ 2
        send_write(CH_ESC);
        send_write(8'h71);
        send_write(CH_ESC);
        send_write(CH_LBRACKET);
        send_write(8'h7A);
        send_write(CH_ESC);
        send_write(CH_LBRACKET);
        send_write(CH_TWO);
        send_write(8'h6B);
        send_clear();
        wait_drained();

        // random phases, each loading an attribute and setting an idle and stall mix
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    load_attr(8'h00);
                end
                1: begin
                    idle_pct = 87;
                    stall_pct <= 0;
                    load_attr(8'hFF);
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 87;
                    load_attr(ATTR_W'($urandom_range(0, 255)));
                end
                3: begin
                    idle_pct = 38;
                    stall_pct <= 38;
                    load_attr(ATTR_W'($urandom_range(0, 255)));
                end
                default: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    load_attr(ATTR_W'($urandom_range(0, 255)));
                    // receiver holds off while requests keep coming
                    fork
                        begin
                            rsp_hold <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge i_clk);
                            rsp_hold <= 1'b0;
                        end
                    join_none
                end
            endcase
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                play_sequence();
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("text_console_engine: match");
        end else begin
            $display("text_console_engine: mismatch");
        end
        $finish;
    end

endmodule
